// ===== hw/rtl/fibsum_pkg.sv =====
// Package for the Fibonacci sum modulo prime block: widths, the prime,
// the Barrett reduction constant and the symmetric matrix type.
// No dependencies.
package fibsum_pkg;

  localparam int unsigned INDEX_BITS = 30;
  // The exponent 2n+3 needs two bits more than the index.
  localparam int unsigned EXP_BITS   = INDEX_BITS + 2;
  localparam int unsigned RES_BITS   = 30;

  localparam logic [RES_BITS-1:0] PRIME_MOD = 30'd998244353;
  localparam logic [31:0]         PRIME_X2  = 32'd1996488706;

  // Barrett constant floor(2^60 / p); it fits in 31 bits.
  localparam logic [63:0] MU_FULL    = (64'd1 << 60) / 64'd998244353;
  localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

  // Powers of the Fibonacci matrix are symmetric: [[e0, e1], [e1, e2]].
  typedef struct packed {
    logic [RES_BITS-1:0] e0;
    logic [RES_BITS-1:0] e1;
    logic [RES_BITS-1:0] e2;
  } mat_t;

endpackage

// ===== hw/rtl/fibonacci_sum_mod_prime.sv =====
// Top level of the Fibonacci sum modulo prime block: matrix power by
// square-and-multiply on one shared 32x32 multiplier with Barrett reduction.
// Depends on fibsum_pkg.
//
//   Channel   Ports                      Direction  Transfer
//   --------  -------------------------  ---------  -------------------------------
//   command   start, busy, index_i       in         edge with start high, busy low
//   result    done_o, fib_sum_o          out        edge ending the done_o cycle
//
// Each command is worked on alone, and busy stays high until its result is out.
// The exponent m = 2n+3 costs K = (bit length of m - 1) + (ones in m) matrix
// products. Each product is four modular multiplies of four steps each, three
// of them passes through the single multiplier, then a sum step and a finish
// step, plus one bit-scan step. The result strobe is registered from the
// bit-scan step that finds the exponent at zero.
// Reset clears the sequencer and the result port only; the receiver cannot
// stall, so every result is shown for exactly one cycle.
module fibonacci_sum_mod_prime (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [29:0]                     index_i,
  output logic [fibsum_pkg::RES_BITS-1:0] fib_sum_o,
  output logic                            done_o
);

  // The sequencer steps through one modular multiply as MUL (operand
  // product), MU (product times the Barrett constant), QP (quotient times
  // the prime) and RED (subtract and final correction).
  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_MUL,
    S_MU,
    S_QP,
    S_RED,
    S_SUM,
    S_FIN
  } state_e;

  // Which product is in progress: accumulator times base, or base squared.
  typedef enum logic {
    PROD_ACC,
    PROD_SQR
  } prod_e;

  state_e state_q, state_d;
  prod_e  prod_sel_q;

  logic [1:0]                          step_q;
  logic [fibsum_pkg::EXP_BITS-1:0]     exp_q;
  logic [fibsum_pkg::EXP_BITS-1:0]     exp_init;
  fibsum_pkg::mat_t                    acc_q;
  fibsum_pkg::mat_t                    base_q;
  fibsum_pkg::mat_t                    lhs;
  logic [63:0]                         prod_q;
  logic [63:0]                         mul_p;
  logic [31:0]                         mul_a;
  logic [31:0]                         mul_b;
  logic [31:0]                         xlo_q;
  logic [fibsum_pkg::RES_BITS-1:0]     term_q [4];
  logic [fibsum_pkg::RES_BITS-1:0]     r01_q;
  logic [fibsum_pkg::RES_BITS-1:0]     r11_q;
  logic [fibsum_pkg::RES_BITS-1:0]     opx;
  logic [fibsum_pkg::RES_BITS-1:0]     opy;
  logic [31:0]                         rem_raw;
  logic [31:0]                         rem_fix;
  logic [fibsum_pkg::RES_BITS-1:0]     red_res;
  logic [fibsum_pkg::RES_BITS:0]       sum01;
  logic [fibsum_pkg::RES_BITS:0]       sum23;
  logic [fibsum_pkg::RES_BITS-1:0]     r01_new;
  logic [fibsum_pkg::RES_BITS-1:0]     r11_new;
  logic [fibsum_pkg::RES_BITS-1:0]     e0_new;
  logic [fibsum_pkg::RES_BITS-1:0]     fib_val;
  logic                                accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // The exponent is 2n+3, formed from the index bits in use.
  assign exp_init = {1'b0, index_i[fibsum_pkg::INDEX_BITS-1:0], 1'b1}
                    + fibsum_pkg::EXP_BITS'(2);

  assign lhs = (prod_sel_q == PROD_SQR) ? base_q : acc_q;

  // For powers X and Y of the Fibonacci matrix the product Z has
  //   z1 = x0*y1 + x1*y2,  z2 = x1*y1 + x2*y2,  z0 = z2 - z1,
  // so four multiplies cover the whole 2x2 product.
  always_comb begin
    case (step_q)
      2'd0: begin
        opx = lhs.e0;
        opy = base_q.e1;
      end
      2'd1: begin
        opx = lhs.e1;
        opy = base_q.e2;
      end
      2'd2: begin
        opx = lhs.e1;
        opy = base_q.e1;
      end
      default: begin
        opx = lhs.e2;
        opy = base_q.e2;
      end
    endcase
  end

  // Operand steering for the one shared multiplier.
  always_comb begin
    unique case (state_q)
      S_MU: begin
        // floor(x / 2^29) times the Barrett constant.
        mul_a = {1'b0, prod_q[59:29]};
        mul_b = {1'b0, fibsum_pkg::BARRETT_MU};
      end
      S_QP: begin
        // The quotient estimate floor(. / 2^31) times the prime.
        mul_a = {2'b00, prod_q[60:31]};
        mul_b = {2'b00, fibsum_pkg::PRIME_MOD};
      end
      default: begin
        mul_a = {2'b00, opx};
        mul_b = {2'b00, opy};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // The Barrett remainder is below three times the prime, and it fits in
  // 32 bits, so only the low words of x and q*p are needed.
  assign rem_raw = xlo_q - prod_q[31:0];

  always_comb begin
    if (rem_raw >= fibsum_pkg::PRIME_X2) begin
      rem_fix = rem_raw - fibsum_pkg::PRIME_X2;
    end else if (rem_raw >= {2'b00, fibsum_pkg::PRIME_MOD}) begin
      rem_fix = rem_raw - {2'b00, fibsum_pkg::PRIME_MOD};
    end else begin
      rem_fix = rem_raw;
    end
  end

  assign red_res = rem_fix[fibsum_pkg::RES_BITS-1:0];

  // Modular sums of the partial products.
  assign sum01 = {1'b0, term_q[0]} + {1'b0, term_q[1]};
  assign sum23 = {1'b0, term_q[2]} + {1'b0, term_q[3]};
  assign r01_new = (sum01 >= {1'b0, fibsum_pkg::PRIME_MOD})
                   ? fibsum_pkg::RES_BITS'(sum01 - {1'b0, fibsum_pkg::PRIME_MOD})
                   : sum01[fibsum_pkg::RES_BITS-1:0];
  assign r11_new = (sum23 >= {1'b0, fibsum_pkg::PRIME_MOD})
                   ? fibsum_pkg::RES_BITS'(sum23 - {1'b0, fibsum_pkg::PRIME_MOD})
                   : sum23[fibsum_pkg::RES_BITS-1:0];

  // Modular difference for the diagonal entry; the wrap in 30 bits lands
  // on the right value because the true result lies below the prime.
  assign e0_new = (r11_q >= r01_q) ? (r11_q - r01_q)
                                   : (r11_q - r01_q + fibsum_pkg::PRIME_MOD);

  // F(m) minus one, with zero wrapping to p-1.
  assign fib_val = (acc_q.e1 == '0) ? (fibsum_pkg::PRIME_MOD - 1'b1)
                                    : (acc_q.e1 - 1'b1);

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_BIT;
        end
      end
      S_BIT: begin
        if (exp_q == '0) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_MU;
      S_MU:  state_d = S_QP;
      S_QP:  state_d = S_RED;
      S_RED: begin
        if (step_q == 2'd3) begin
          state_d = S_SUM;
        end else begin
          state_d = S_MUL;
        end
      end
      S_SUM: state_d = S_FIN;
      S_FIN: state_d = S_BIT;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer state and the registered result port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_o    <= 1'b0;
      fib_sum_o <= '0;
    end else begin
      state_q <= state_d;
      done_o  <= 1'b0;
      if (state_q == S_BIT && exp_q == '0) begin
        done_o    <= 1'b1;
        fib_sum_o <= fib_val;
      end
    end
  end

  // Datapath registers; every one is loaded before it is read.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          exp_q  <= exp_init;
          acc_q  <= '{e0: 30'd1, e1: 30'd0, e2: 30'd1};
          base_q <= '{e0: 30'd0, e1: 30'd1, e2: 30'd1};
        end
      end
      S_BIT: begin
        // A set low bit folds the base into the accumulator first; otherwise
        // the base is squared and the exponent moves down one bit.
        prod_sel_q <= exp_q[0] ? PROD_ACC : PROD_SQR;
        step_q     <= 2'd0;
      end
      S_MUL: begin
        prod_q <= mul_p;
      end
      S_MU: begin
        xlo_q  <= prod_q[31:0];
        prod_q <= mul_p;
      end
      S_QP: begin
        prod_q <= mul_p;
      end
      S_RED: begin
        term_q[step_q] <= red_res;
        step_q         <= step_q + 2'd1;
      end
      S_SUM: begin
        r01_q <= r01_new;
        r11_q <= r11_new;
      end
      S_FIN: begin
        if (prod_sel_q == PROD_ACC) begin
          acc_q    <= '{e0: e0_new, e1: r01_q, e2: r11_q};
          exp_q[0] <= 1'b0;
        end else begin
          base_q <= '{e0: e0_new, e1: r01_q, e2: r11_q};
          exp_q  <= exp_q >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  // A result is only shown once the sequencer has returned to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Every result lies below the prime.
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (fib_sum_o < fibsum_pkg::PRIME_MOD))
    else $error("result out of range");

  // The Barrett correction always brings the remainder below the prime.
  a_reduce_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RED) |-> (rem_fix < {2'b00, fibsum_pkg::PRIME_MOD}))
    else $error("modular reduction left remainder too large");

  // A command transfer starts the work at once.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && !done_o))
    else $error("command transfer did not start work");

endmodule
